[sv/dpq_pkg.sv]
package dpq_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam logic [2:0] OP_ENQUEUE  = 3'd0;
	localparam logic [2:0] OP_DEQ_HIGH = 3'd1;
	localparam logic [2:0] OP_DEQ_LOW  = 3'd2;
	localparam logic [2:0] OP_LOOKUP   = 3'd3;
	localparam logic [2:0] OP_CLEAR    = 3'd4;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_EMPTY    = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;
	localparam logic [1:0] STAT_NOTFOUND = 2'd3;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_INSERT,
		CMD_SHIFT,
		CMD_MATCH
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t  cmd;
		logic [7:0] new_prio;
	} cell_ctl_t;

endpackage

[sv/dpq_cell.sv]
module dpq_cell #(
	parameter int DATA_WIDTH = dpq_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dpq_pkg::cell_ctl_t    ctl,
	input  logic [DATA_WIDTH-1:0] new_data,
	input  logic                  occupied,
	input  logic                  left_after,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic [7:0]            left_prio,
	input  logic [DATA_WIDTH-1:0] right_data,
	input  logic [7:0]            right_prio,
	input  logic                  right_match,
	output logic                  after,
	output logic [DATA_WIDTH-1:0] data,
	output logic [7:0]            prio,
	output logic                  match
);

	logic [DATA_WIDTH-1:0] data_q;
	logic [7:0]            prio_q;
	logic                  match_q;

	// An incoming item stays behind every stored entry of equal or higher priority.
	assign after = occupied && (prio_q >= ctl.new_prio);
	assign data  = data_q;
	assign prio  = prio_q;
	assign match = match_q;

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			dpq_pkg::CMD_INSERT: begin
				if (!after) begin
					if (left_after) begin
						data_q <= new_data;
						prio_q <= ctl.new_prio;
					end else begin
						data_q <= left_data;
						prio_q <= left_prio;
					end
				end
			end
			dpq_pkg::CMD_SHIFT: begin
				data_q <= right_data;
				prio_q <= right_prio;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else begin
			case (ctl.cmd)
				dpq_pkg::CMD_SHIFT: match_q <= right_match;
				dpq_pkg::CMD_MATCH: match_q <= occupied && (data_q == new_data);
				default:            match_q <= match_q;
			endcase
		end
	end

endmodule

[sv/double_ended_priority_queue.sv]
// Double-ended priority queue built as a row of CAPACITY cells, front at cell 0.
// Input channel (in_valid/in_ready) takes one operation per beat: enqueue,
// dequeue highest, dequeue lowest, lookup by data or clear. Output channel
// (out_valid/out_ready) gives one result beat per operation, or one beat per
// matching entry for a lookup; the final beat of an operation carries last.
// Enqueue and dequeue highest update every cell at once; dequeue lowest and clear
// change only the entry count. Each then reports through the report state once the
// output register is free, and only after that is a new operation taken. A lookup
// compares in its accept cycle and then rotates the whole row once through cell 0,
// one cell per cycle unless a match beat waits on the receiver; a not-found or
// empty beat goes through the report state; match beats leave at cell 0, front to rear.
// The queue takes no new operation until all beats of the current one are
// loaded into the output register. When the receiver stalls, the output
// register holds its beat, and a lookup pauses its rotation on a match.
// Reset empties the queue and drops any pending beat; stored data is left as is.
module double_ended_priority_queue #(
	parameter int CAPACITY   = dpq_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = dpq_pkg::DATA_WIDTH_DEF,
	localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [2:0]                   op,
	input  logic signed [DATA_WIDTH-1:0] item_data,
	input  logic [7:0]                   item_priority,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   status,
	output logic                         found,
	output logic [7:0]                   match_priority,
	output logic signed [DATA_WIDTH-1:0] front_data,
	output logic signed [DATA_WIDTH-1:0] rear_data,
	output logic [CNT_W-1:0]             entry_count,
	output logic                         last
);

	localparam int IDX_W = $clog2(CAPACITY);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REPORT,
		ST_SCAN
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      count_q;
	logic [IDX_W-1:0]      scan_idx_q;
	logic                  emitted_q;
	logic [1:0]            rep_status_q;
	logic [DATA_WIDTH-1:0] snap_front_q;
	logic [DATA_WIDTH-1:0] snap_rear_q;

	logic                  out_valid_q;
	logic [1:0]            status_q;
	logic                  found_q;
	logic [7:0]            match_prio_q;
	logic [DATA_WIDTH-1:0] front_q;
	logic [DATA_WIDTH-1:0] rear_q;
	logic [CNT_W-1:0]      out_count_q;
	logic                  last_q;

	dpq_pkg::cell_ctl_t    cell_ctl;
	logic [DATA_WIDTH-1:0] cell_data  [CAPACITY];
	logic [7:0]            cell_prio  [CAPACITY];
	logic [CAPACITY-1:0]   cell_after;
	logic [CAPACITY-1:0]   cell_match;
	logic [CAPACITY-1:0]   cell_occ;

	logic                  accept;
	logic                  out_free;
	logic                  out_load;
	logic                  is_empty;
	logic                  is_full;
	logic                  hit;
	logic                  more_hits;
	logic                  scan_step;
	logic                  scan_end;
	logic [DATA_WIDTH-1:0] live_front;
	logic [DATA_WIDTH-1:0] live_rear;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || out_ready;
	assign is_empty  = (count_q == '0);
	assign is_full   = (count_q == CNT_W'(CAPACITY));
	assign hit       = cell_match[0];
	assign more_hits = |cell_match[CAPACITY-1:1];
	assign scan_step = (state_q == ST_SCAN) && (!hit || out_free);
	assign scan_end  = (scan_idx_q == IDX_W'(CAPACITY - 1));
	assign out_load  = ((state_q == ST_REPORT) && out_free) || (scan_step && hit);

	assign live_front = is_empty ? '0 : cell_data[0];

	always_comb begin
		live_rear = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (count_q == CNT_W'(i + 1)) begin
				live_rear = cell_data[i];
			end
		end
	end

	always_comb begin
		cell_ctl.cmd      = dpq_pkg::CMD_HOLD;
		cell_ctl.new_prio = item_priority;
		if (accept) begin
			unique case (op)
				dpq_pkg::OP_ENQUEUE: begin
					if (!is_full) begin
						cell_ctl.cmd = dpq_pkg::CMD_INSERT;
					end
				end
				dpq_pkg::OP_DEQ_HIGH: begin
					if (!is_empty) begin
						cell_ctl.cmd = dpq_pkg::CMD_SHIFT;
					end
				end
				dpq_pkg::OP_LOOKUP: cell_ctl.cmd = dpq_pkg::CMD_MATCH;
				default:            cell_ctl.cmd = dpq_pkg::CMD_HOLD;
			endcase
		end else if (scan_step) begin
			cell_ctl.cmd = dpq_pkg::CMD_SHIFT;
		end
	end

	// Each cell shifts toward the front; the last cell takes cell 0 back so a
	// full rotation restores the order. A match bit is dropped as it wraps.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign cell_occ[i] = (count_q > CNT_W'(i));

		dpq_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (cell_ctl),
			.new_data   ($unsigned(item_data)),
			.occupied   (cell_occ[i]),
			.left_after ((i == 0) ? 1'b1 : cell_after[(i == 0) ? 0 : i - 1]),
			.left_data  (cell_data[(i == 0) ? 0 : i - 1]),
			.left_prio  (cell_prio[(i == 0) ? 0 : i - 1]),
			.right_data (cell_data[(i == CAPACITY - 1) ? 0 : i + 1]),
			.right_prio (cell_prio[(i == CAPACITY - 1) ? 0 : i + 1]),
			.right_match((i == CAPACITY - 1) ? 1'b0 : cell_match[(i == CAPACITY - 1) ? 0 : i + 1]),
			.after      (cell_after[i]),
			.data       (cell_data[i]),
			.prio       (cell_prio[i]),
			.match      (cell_match[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			scan_idx_q   <= '0;
			emitted_q    <= 1'b0;
			rep_status_q <= dpq_pkg::STAT_OK;
			snap_front_q <= '0;
			snap_rear_q  <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= dpq_pkg::STAT_OK;
			found_q      <= 1'b0;
			match_prio_q <= '0;
			front_q      <= '0;
			rear_q       <= '0;
			out_count_q  <= '0;
			last_q       <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (op == dpq_pkg::OP_LOOKUP) ? ST_SCAN : ST_REPORT;
						unique case (op)
							dpq_pkg::OP_ENQUEUE: begin
								if (is_full) begin
									rep_status_q <= dpq_pkg::STAT_FULL;
								end else begin
									rep_status_q <= dpq_pkg::STAT_OK;
									count_q      <= count_q + 1'b1;
								end
							end
							dpq_pkg::OP_DEQ_HIGH, dpq_pkg::OP_DEQ_LOW: begin
								if (is_empty) begin
									rep_status_q <= dpq_pkg::STAT_EMPTY;
								end else begin
									rep_status_q <= dpq_pkg::STAT_OK;
									count_q      <= count_q - 1'b1;
								end
							end
							dpq_pkg::OP_LOOKUP: begin
								scan_idx_q   <= '0;
								emitted_q    <= 1'b0;
								snap_front_q <= live_front;
								snap_rear_q  <= live_rear;
							end
							dpq_pkg::OP_CLEAR: begin
								rep_status_q <= dpq_pkg::STAT_OK;
								count_q      <= '0;
							end
							default: rep_status_q <= dpq_pkg::STAT_OK;
						endcase
					end
				end
				ST_REPORT: begin
					if (out_free) begin
						state_q      <= ST_IDLE;
						status_q     <= rep_status_q;
						found_q      <= 1'b0;
						match_prio_q <= '0;
						front_q      <= live_front;
						rear_q       <= live_rear;
						out_count_q  <= count_q;
						last_q       <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (scan_step) begin
						scan_idx_q <= scan_idx_q + 1'b1;
						if (hit) begin
							emitted_q    <= 1'b1;
							status_q     <= dpq_pkg::STAT_OK;
							found_q      <= 1'b1;
							match_prio_q <= cell_prio[0];
							front_q      <= snap_front_q;
							rear_q       <= snap_rear_q;
							out_count_q  <= count_q;
							last_q       <= !more_hits;
						end
						if (scan_end) begin
							if (emitted_q || hit) begin
								state_q <= ST_IDLE;
							end else begin
								state_q      <= ST_REPORT;
								rep_status_q <= is_empty ? dpq_pkg::STAT_EMPTY
								                         : dpq_pkg::STAT_NOTFOUND;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign found          = found_q;
	assign match_priority = match_prio_q;
	assign front_data     = $signed(front_q);
	assign rear_data      = $signed(rear_q);
	assign entry_count    = out_count_q;
	assign last           = last_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_idle_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (cell_match == '0))
		else $error("match bits left over after a lookup");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && found_q |-> (status_q == dpq_pkg::STAT_OK))
		else $error("match beat with a status other than ok");

	a_no_stomp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(status_q) && $stable(last_q))
		else $error("stalled result beat overwritten");

	a_match_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_match & ~cell_occ) == '0)
		else $error("match bit outside the stored entries");
`endif

endmodule

[verif/dpq_report_checker.sv]
`timescale 1ns / 1ps

module dpq_report_checker (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        in_valid,
	input  logic                                        in_ready,
	input  logic [2:0]                                  op,
	input  logic signed [dpq_pkg::DATA_WIDTH_DEF-1:0]   item_data,
	input  logic [7:0]                                  item_priority,
	input  logic                                        out_valid,
	input  logic                                        out_ready,
	input  logic [1:0]                                  status,
	input  logic                                        found,
	input  logic [7:0]                                  match_priority,
	input  logic signed [dpq_pkg::DATA_WIDTH_DEF-1:0]   front_data,
	input  logic signed [dpq_pkg::DATA_WIDTH_DEF-1:0]   rear_data,
	input  logic [$clog2(dpq_pkg::CAPACITY_DEF+1)-1:0]  entry_count,
	input  logic                                        last,
	output int                                          mismatches,
	output int                                          outstanding,
	output int                                          ops_taken,
	output int                                          reports_seen,
	output int                                          match_reports,
	output int                                          full_drops
);

	localparam int CAP   = dpq_pkg::CAPACITY_DEF;
	localparam int DW    = dpq_pkg::DATA_WIDTH_DEF;
	localparam int CNT_W = $clog2(CAP + 1);

	typedef struct packed {
		logic [1:0]       status;
		logic             found;
		logic [7:0]       match_priority;
		logic [DW-1:0]    front_data;
		logic [DW-1:0]    rear_data;
		logic [CNT_W-1:0] entry_count;
		logic             last;
	} report_t;

	// Shadow copy of the queue contents, front at index 0.
	logic [DW-1:0] shadow_data [CAP];
	logic [7:0]    shadow_prio [CAP];
	int            shadow_fill;

	report_t due_reports [$];

	function automatic void queue_report(input logic [1:0] st, input logic hit,
		input logic [7:0] pr, input logic fin);
		report_t r;
		r.status         = st;
		r.found          = hit;
		r.match_priority = pr;
		r.front_data     = (shadow_fill != 0) ? shadow_data[0] : '0;
		r.rear_data      = (shadow_fill != 0) ? shadow_data[shadow_fill-1] : '0;
		r.entry_count    = CNT_W'(shadow_fill);
		r.last           = fin;
		due_reports.push_back(r);
	endfunction

	task automatic apply_operation(input logic [2:0] code, input logic [DW-1:0] d,
		input logic [7:0] p);
		int pos;
		int i;
		int hits;
		int seen;
		case (code)
			dpq_pkg::OP_ENQUEUE: begin
				if (shadow_fill >= CAP) begin
					queue_report(dpq_pkg::STAT_FULL, 1'b0, 8'd0, 1'b1);
				end else begin
					// New entry goes behind every entry of equal or higher priority.
					pos = 0;
					while (pos < shadow_fill && shadow_prio[pos] >= p)
						pos++;
					for (i = shadow_fill; i > pos; i--) begin
						shadow_data[i] = shadow_data[i-1];
						shadow_prio[i] = shadow_prio[i-1];
					end
					shadow_data[pos] = d;
					shadow_prio[pos] = p;
					shadow_fill++;
					queue_report(dpq_pkg::STAT_OK, 1'b0, 8'd0, 1'b1);
				end
			end
			dpq_pkg::OP_DEQ_HIGH: begin
				if (shadow_fill == 0) begin
					queue_report(dpq_pkg::STAT_EMPTY, 1'b0, 8'd0, 1'b1);
				end else begin
					for (i = 1; i < shadow_fill; i++) begin
						shadow_data[i-1] = shadow_data[i];
						shadow_prio[i-1] = shadow_prio[i];
					end
					shadow_fill--;
					queue_report(dpq_pkg::STAT_OK, 1'b0, 8'd0, 1'b1);
				end
			end
			dpq_pkg::OP_DEQ_LOW: begin
				if (shadow_fill == 0) begin
					queue_report(dpq_pkg::STAT_EMPTY, 1'b0, 8'd0, 1'b1);
				end else begin
					shadow_fill--;
					queue_report(dpq_pkg::STAT_OK, 1'b0, 8'd0, 1'b1);
				end
			end
			dpq_pkg::OP_LOOKUP: begin
				if (shadow_fill == 0) begin
					queue_report(dpq_pkg::STAT_EMPTY, 1'b0, 8'd0, 1'b1);
				end else begin
					hits = 0;
					for (i = 0; i < shadow_fill; i++)
						if (shadow_data[i] == d)
							hits++;
					if (hits == 0) begin
						queue_report(dpq_pkg::STAT_NOTFOUND, 1'b0, 8'd0, 1'b1);
					end else begin
						seen = 0;
						for (i = 0; i < shadow_fill; i++) begin
							if (shadow_data[i] == d) begin
								seen++;
								queue_report(dpq_pkg::STAT_OK, 1'b1, shadow_prio[i],
									seen == hits);
							end
						end
					end
				end
			end
			dpq_pkg::OP_CLEAR: begin
				shadow_fill = 0;
				queue_report(dpq_pkg::STAT_OK, 1'b0, 8'd0, 1'b1);
			end
			default: begin
				queue_report(dpq_pkg::STAT_OK, 1'b0, 8'd0, 1'b1);
			end
		endcase
	endtask

	function automatic int compare_report(input report_t want, input report_t got);
		int bad;
		bad = 0;
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			bad++;
		end
		if (got.found !== want.found) begin
			$error("found: expected %0d, got %0d", want.found, got.found);
			bad++;
		end
		if (got.match_priority !== want.match_priority) begin
			$error("match_priority: expected %0d, got %0d", want.match_priority,
				got.match_priority);
			bad++;
		end
		if (got.front_data !== want.front_data) begin
			$error("front_data: expected %0d, got %0d", $signed(want.front_data),
				$signed(got.front_data));
			bad++;
		end
		if (got.rear_data !== want.rear_data) begin
			$error("rear_data: expected %0d, got %0d", $signed(want.rear_data),
				$signed(got.rear_data));
			bad++;
		end
		if (got.entry_count !== want.entry_count) begin
			$error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
			bad++;
		end
		if (got.last !== want.last) begin
			$error("last: expected %0d, got %0d", want.last, got.last);
			bad++;
		end
		return bad;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		report_t got;
		if (!arst_n) begin
			due_reports.delete();
			shadow_fill = 0;
			mismatches    <= 0;
			outstanding   <= 0;
			ops_taken     <= 0;
			reports_seen  <= 0;
			match_reports <= 0;
			full_drops    <= 0;
		end else begin
			if (out_valid && out_ready) begin
				got.status         = status;
				got.found          = found;
				got.match_priority = match_priority;
				got.front_data     = front_data;
				got.rear_data      = rear_data;
				got.entry_count    = entry_count;
				got.last           = last;
				if (due_reports.size() == 0) begin
					$error("result beat with nothing outstanding: status %0d, count %0d",
						status, entry_count);
					mismatches <= mismatches + 1;
				end else begin
					mismatches <= mismatches + compare_report(due_reports.pop_front(), got);
				end
				reports_seen <= reports_seen + 1;
				if (found)
					match_reports <= match_reports + 1;
				if (status == dpq_pkg::STAT_FULL)
					full_drops <= full_drops + 1;
			end
			if (in_valid && in_ready) begin
				apply_operation(op, item_data, item_priority);
				ops_taken <= ops_taken + 1;
			end
			outstanding <= due_reports.size();
		end
	end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;

	localparam int CAP       = dpq_pkg::CAPACITY_DEF;
	localparam int DW        = dpq_pkg::DATA_WIDTH_DEF;
	localparam int CNT_W     = $clog2(CAP + 1);
	localparam int LONG_HOLD = 120;

	// Op codes the block does not define; they must still give one beat.
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	typedef enum int {
		LEAN_FILL,
		LEAN_DRAIN,
		LEAN_EVEN
	} lean_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [2:0]           op;
	logic signed [DW-1:0] item_data;
	logic [7:0]           item_priority;
	logic                 out_valid;
	logic                 out_ready;
	logic [1:0]           status;
	logic                 found;
	logic [7:0]           match_priority;
	logic signed [DW-1:0] front_data;
	logic signed [DW-1:0] rear_data;
	logic [CNT_W-1:0]     entry_count;
	logic                 last;

	int mismatches;
	int outstanding;
	int ops_taken;
	int reports_seen;
	int match_reports;
	int full_drops;

	bit quiet     = 1'b0;
	int stall_req = 0;

	// A small value pool makes lookups hit, often on several entries at once.
	logic signed [DW-1:0] data_pool [0:5] = '{32'sd0, -32'sd1, 32'sh7fffffff,
		32'sh80000000, 32'sd17, -32'sd300};
	logic [7:0] prio_pool [0:3] = '{8'd0, 8'd64, 8'd128, 8'd255};

	double_ended_priority_queue dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.item_data      (item_data),
		.item_priority  (item_priority),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.found          (found),
		.match_priority (match_priority),
		.front_data     (front_data),
		.rear_data      (rear_data),
		.entry_count    (entry_count),
		.last           (last)
	);

	dpq_report_checker report_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.item_data      (item_data),
		.item_priority  (item_priority),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.found          (found),
		.match_priority (match_priority),
		.front_data     (front_data),
		.rear_data      (rear_data),
		.entry_count    (entry_count),
		.last           (last),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.ops_taken      (ops_taken),
		.reports_seen   (reports_seen),
		.match_reports  (match_reports),
		.full_drops     (full_drops)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("tb: failure");
		$finish;
	end

	function automatic int idle_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 96)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic signed [DW-1:0] pick_data();
		if ($urandom_range(0, 99) < 75)
			return data_pool[$urandom_range(0, 5)];
		return $urandom;
	endfunction

	function automatic logic [7:0] pick_prio();
		if ($urandom_range(0, 99) < 45)
			return prio_pool[$urandom_range(0, 3)];
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_op(input logic [2:0] code, input logic signed [DW-1:0] d,
		input logic [7:0] p);
		int gap;
		op            <= code;
		item_data     <= d;
		item_priority <= p;
		in_valid      <= 1'b1;
		do @(posedge clk); while (!in_ready);
		gap = idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_reports();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic random_phase(input lean_t lean, input int n);
		int roll;
		int enq_pct;
		int deq_pct;
		int look_pct;
		logic [2:0] code;
		case (lean)
			LEAN_FILL: begin
				enq_pct = 70; deq_pct = 10; look_pct = 15;
			end
			LEAN_DRAIN: begin
				enq_pct = 25; deq_pct = 60; look_pct = 10;
			end
			default: begin
				enq_pct = 45; deq_pct = 30; look_pct = 20;
			end
		endcase
		repeat (n) begin
			roll = $urandom_range(0, 99);
			if (roll < enq_pct)
				code = dpq_pkg::OP_ENQUEUE;
			else if (roll < enq_pct + deq_pct)
				code = $urandom_range(0, 1) ? dpq_pkg::OP_DEQ_HIGH : dpq_pkg::OP_DEQ_LOW;
			else if (roll < enq_pct + deq_pct + look_pct)
				code = dpq_pkg::OP_LOOKUP;
			else if (roll < 98)
				code = dpq_pkg::OP_CLEAR;
			else
				code = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
			send_op(code, pick_data(), pick_prio());
		end
	endtask

	// Receiver: bursts of ready and random stalls, plus one long hold-off on request.
	initial begin
		int served;
		served = 0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (stall_req != served) begin
				served = stall_req;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (quiet || $urandom_range(0, 2) != 0) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat (idle_gap() + 1) @(posedge clk);
			end
		end
	end

	initial begin
		int k;
		logic signed [DW-1:0] d;
		logic [7:0] p;
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		op            <= dpq_pkg::OP_ENQUEUE;
		item_data     <= '0;
		item_priority <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Dequeues, lookup and clear on an empty queue first, then the undefined op codes.
		send_op(dpq_pkg::OP_DEQ_HIGH, 32'sd0, 8'd0);
		send_op(dpq_pkg::OP_DEQ_LOW, 32'sd0, 8'd0);
		send_op(dpq_pkg::OP_LOOKUP, 32'sd5, 8'd0);
		send_op(dpq_pkg::OP_CLEAR, 32'sd0, 8'd0);
		for (k = OP_SPARE_LO; k <= OP_SPARE_HI; k++)
			send_op(3'(k), -32'sd1, 8'd255);

		// Fill to capacity with extreme values, repeated data and tied priorities.
		for (k = 0; k < CAP; k++) begin
			case (k % 4)
				0: d = 32'sh7fffffff;
				1: d = 32'sh80000000;
				2: d = -32'sd1;
				default: d = k;
			endcase
			p = (k % 3 == 0) ? 8'd255 : ((k % 3 == 1) ? 8'd0 : 8'd128);
			send_op(dpq_pkg::OP_ENQUEUE, d, p);
		end
		send_op(dpq_pkg::OP_ENQUEUE, 32'sd42, 8'd255);
		send_op(dpq_pkg::OP_LOOKUP, -32'sd1, 8'd0);
		send_op(dpq_pkg::OP_LOOKUP, 32'sd99, 8'd0);
		send_op(dpq_pkg::OP_DEQ_HIGH, 32'sd0, 8'd0);
		send_op(dpq_pkg::OP_DEQ_LOW, 32'sd0, 8'd0);
		send_op(dpq_pkg::OP_CLEAR, 32'sd0, 8'd0);

		quiet = 1'b1;
		random_phase(LEAN_FILL, 15);
		quiet = 1'b0;
		random_phase(LEAN_EVEN, 15);
		drain_reports();

		// The receiver holds off while operations keep coming, so the input stalls.
		stall_req <= stall_req + 1;
		random_phase(LEAN_FILL, 10);
		random_phase(LEAN_DRAIN, 15);
		random_phase(LEAN_FILL, 20);
		drain_reports();
		random_phase(LEAN_EVEN, 12);
		random_phase(LEAN_DRAIN, 14);

		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4 * CAP) @(posedge clk);

		$display("run covered %0d operations and %0d result beats,", ops_taken, reports_seen);
		$display("including %0d lookup matches and %0d full-queue drops", match_reports,
			full_drops);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[files.f]
sv/dpq_pkg.sv
sv/dpq_cell.sv
sv/double_ended_priority_queue.sv
verif/dpq_report_checker.sv
verif/tb.sv
